// ===== rtl/csrc_pkg.sv =====
package csrc_pkg;

  // Action codes carried in the request beat.
  localparam logic [1:0] ACT_GET      = 2'd0;
  localparam logic [1:0] ACT_PUT      = 2'd1;
  localparam logic [1:0] ACT_CONTAINS = 2'd2;
  localparam logic [1:0] ACT_SWEEP    = 2'd3;

  // Capacity register width and its value after reset.
  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] ACTIVE_FRAMES_RESET = 5'd16;

  // Request beat.
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] key;
  } req_t;

  // Response beat.
  typedef struct packed {
    logic        hit;
    logic [31:0] value;
    logic [3:0]  slot;
    logic        evicted;
    logic [31:0] evicted_key;
    logic [4:0]  occupancy;
  } rsp_t;

endpackage

// ===== rtl/csrc_ram.sv =====
module csrc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read of the address being written returns the old word.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// ===== rtl/clock_sweep_replacement_cache.sv =====
// Channel  | Direction | Handshake                  | Beat
// ---------+-----------+----------------------------+------------------------------
// req      | in        | req_valid / req_stall      | csrc_pkg::req_t (action, key)
// rsp      | out       | rsp_valid / rsp_stall      | csrc_pkg::rsp_t (six fields)
// cfg      | in        | cfg_valid / cfg_ready      | active_frames, 5 bits
//
// One request is worked on at a time; n is the clamped capacity. A sweep clears every
// referenced bit; a get or contains reads the key memory one frame a cycle over up to n
// frames and compares each word once it has been read. A put that misses then walks the
// frames from the hand, fills the chosen frame and picks up the evicted key.
// A stalled response beat holds the next result back; a capacity write beats a request.
// Reset (rst, synchronous) empties the store and sets the capacity to 16.
module clock_sweep_replacement_cache #(
  parameter int unsigned FRAMES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  csrc_pkg::req_t                req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output csrc_pkg::rsp_t                rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [csrc_pkg::CAP_W-1:0]    cfg_data
);

  localparam int unsigned IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned NW = $clog2(FRAMES + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOOK = 6'b000010,
    S_WALK = 6'b000100,
    S_FILL = 6'b001000,
    S_EVK  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                      state;
  logic [csrc_pkg::CAP_W-1:0]  active_frames;
  logic [FRAMES-1:0]           frame_valid;
  logic [FRAMES-1:0]           frame_referenced;
  logic [IW-1:0]               hand;
  logic [NW-1:0]               valid_count;
  logic [1:0]                  act;
  logic [31:0]                 key;
  logic [NW-1:0]               scan_idx;
  logic                        pend;
  logic [IW-1:0]               pend_idx;
  logic [IW-1:0]               walk_idx;
  logic [IW-1:0]               target;
  csrc_pkg::rsp_t              res;

  logic [NW-1:0]               cap;
  logic                        full;
  logic                        ram_we;
  logic [IW-1:0]               ram_rd_addr;
  logic [31:0]                 ram_rd_data;
  logic [IW-1:0]               walk_inc;
  logic [IW-1:0]               target_inc;
  logic [31:0]                 target_ext;
  logic [31:0]                 pend_ext;
  logic [31:0]                 count_ext;
  logic                        rsp_load;
  csrc_pkg::rsp_t              rsp_next;

  // Capacity clamped into 1 .. FRAMES.
  always_comb begin
    if (active_frames == '0) begin
      cap = NW'(1);
    end else if (32'(active_frames) > FRAMES) begin
      cap = NW'(FRAMES);
    end else begin
      cap = NW'(active_frames);
    end
  end

  assign full = (valid_count >= cap);

  // Frame index plus one, wrapping at the capacity.
  assign walk_inc   = (NW'(walk_idx) + NW'(1) == cap) ? '0 : IW'(NW'(walk_idx) + NW'(1));
  assign target_inc = (NW'(target) + NW'(1) == cap) ? '0 : IW'(NW'(target) + NW'(1));

  assign target_ext = 32'(target);
  assign pend_ext   = 32'(pend_idx);
  assign count_ext  = 32'(valid_count);

  // Key memory: scanned during lookup, otherwise addressed at the target frame.
  assign ram_we      = (state == S_FILL);
  assign ram_rd_addr = (state == S_LOOK) ? scan_idx[IW-1:0] : target;

  csrc_ram #(
    .WIDTH (32),
    .DEPTH (FRAMES)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (target),
    .wr_data (key),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // A pending capacity write holds the request channel back.
  assign req_stall = (state != S_IDLE) || cfg_valid;
  assign cfg_ready = (state == S_IDLE);

  // The response register is loaded once it is empty or being emptied.
  assign rsp_load = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  // Control sequencer and store state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      active_frames    <= csrc_pkg::ACTIVE_FRAMES_RESET;
      frame_valid      <= '0;
      frame_referenced <= '0;
      hand             <= '0;
      valid_count      <= '0;
      pend             <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            // A capacity write empties the store.
            active_frames    <= cfg_data;
            frame_valid      <= '0;
            frame_referenced <= '0;
            hand             <= '0;
            valid_count      <= '0;
          end else if (req_valid) begin
            act      <= req.action;
            key      <= req.key;
            res      <= '0;
            scan_idx <= '0;
            pend     <= 1'b0;
            if (NW'(hand) >= cap) begin
              hand <= '0;
            end
            if (req.action == csrc_pkg::ACT_SWEEP) begin
              frame_referenced <= '0;
              state            <= S_DONE;
            end else begin
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          // Issue one read a cycle and compare the word from the previous read.
          if (scan_idx < cap) begin
            scan_idx <= scan_idx + NW'(1);
            pend     <= 1'b1;
            pend_idx <= scan_idx[IW-1:0];
          end else begin
            pend <= 1'b0;
          end
          if (pend && frame_valid[pend_idx] && (ram_rd_data == key)) begin
            res.hit  <= 1'b1;
            res.slot <= pend_ext[3:0];
            if (act == csrc_pkg::ACT_GET) begin
              res.value <= key;
            end
            if (act != csrc_pkg::ACT_CONTAINS) begin
              frame_referenced[pend_idx] <= 1'b1;
            end
            state <= S_DONE;
          end else if (!pend && (scan_idx >= cap)) begin
            if (act == csrc_pkg::ACT_PUT) begin
              walk_idx <= hand;
              state    <= S_WALK;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_WALK: begin
          // Empty frame from the hand onward, or second-chance walk when full.
          if (!full) begin
            if (!frame_valid[walk_idx]) begin
              target <= walk_idx;
              state  <= S_FILL;
            end else begin
              walk_idx <= walk_inc;
            end
          end else if (!frame_referenced[walk_idx]) begin
            target      <= walk_idx;
            res.evicted <= 1'b1;
            state       <= S_FILL;
          end else begin
            frame_referenced[walk_idx] <= 1'b0;
            walk_idx                   <= walk_inc;
          end
        end
        S_FILL: begin
          // The memory writes the new key and returns the old one next cycle.
          frame_valid[target]      <= 1'b1;
          frame_referenced[target] <= 1'b1;
          hand                     <= target_inc;
          res.slot                 <= target_ext[3:0];
          if (!res.evicted) begin
            valid_count <= valid_count + NW'(1);
          end
          state <= S_EVK;
        end
        S_EVK: begin
          if (res.evicted) begin
            res.evicted_key <= ram_rd_data;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          // Hand the result over once the response register is free.
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Response valid: set on a load, cleared when the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Response payload with the occupancy after the action.
  always_comb begin
    rsp_next           = res;
    rsp_next.occupancy = count_ext[4:0];
  end

  // Response payload, loaded together with rsp_valid.
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int FRAMES = 16;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_BEATS = 55;
  localparam int QUIET_PHASE = 6;

  // One line of the directed stimulus: either a capacity write or a request beat.
  typedef struct {
    bit                         is_cfg;
    logic [csrc_pkg::CAP_W-1:0] cap;
    csrc_pkg::req_t             beat;
    bit                         typed;
    csrc_pkg::rsp_t             want;
  } plan_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       req_valid = 1'b0;
  logic                       req_stall;
  csrc_pkg::req_t             req = '0;
  logic                       rsp_valid;
  logic                       rsp_stall = 1'b0;
  csrc_pkg::rsp_t             rsp;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [csrc_pkg::CAP_W-1:0] cfg_data = '0;

  // Shadow copy of the frame store, the clock hand and the capacity register.
  logic [31:0]                shadow_key [FRAMES];
  bit                         shadow_valid [FRAMES];
  bit                         shadow_ref [FRAMES];
  int unsigned                sweep_hand;
  int unsigned                stored_count;
  logic [csrc_pkg::CAP_W-1:0] capacity_reg;

  csrc_pkg::rsp_t             pending_rsp [$];
  plan_row_t                  directed_plan [$];
  logic [csrc_pkg::CAP_W-1:0] phase_caps [RANDOM_PHASES] =
    '{5'd16, 5'd2, 5'd1, 5'd0, 5'd31, 5'd5, 5'd16, 5'd9, 5'd17, 5'd3};

  int mismatches = 0;
  int n_requests = 0;
  int n_hits = 0;
  int n_evictions = 0;
  int n_sweeps = 0;
  int n_settings = 0;
  bit quiet = 1'b0;

  clock_sweep_replacement_cache #(.FRAMES(FRAMES)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Out-of-range capacities are clamped to the range 1 to FRAMES.
  function automatic int unsigned effective_capacity(logic [csrc_pkg::CAP_W-1:0] v);
    if (v == 0) return 1;
    if (v > FRAMES) return FRAMES;
    return 32'(v);
  endfunction

  function automatic void clear_shadow();
    for (int i = 0; i < FRAMES; i++) begin
      shadow_key[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_ref[i] = 1'b0;
    end
    sweep_hand = 0;
    stored_count = 0;
  endfunction

  // Applies one request to the shadow store and returns the beat it should produce.
  function automatic csrc_pkg::rsp_t second_chance_access(csrc_pkg::req_t beat);
    csrc_pkg::rsp_t o;
    int unsigned    n;
    int unsigned    idx;
    int unsigned    tgt;
    int             found_at;
    bit             empty_found;
    o = '0;
    n = effective_capacity(capacity_reg);
    if (sweep_hand >= n) sweep_hand = 0;
    if (beat.action == csrc_pkg::ACT_SWEEP) begin
      for (int i = 0; i < FRAMES; i++) shadow_ref[i] = 1'b0;
    end else begin
      // The lowest matching frame wins.
      found_at = -1;
      for (int i = 0; i < n; i++) begin
        if (found_at < 0 && shadow_valid[i] && shadow_key[i] == beat.key) found_at = i;
      end
      if (found_at >= 0) begin
        o.hit = 1'b1;
        o.slot = 4'(found_at);
        if (beat.action == csrc_pkg::ACT_GET) o.value = beat.key;
        if (beat.action != csrc_pkg::ACT_CONTAINS) shadow_ref[found_at] = 1'b1;
      end else if (beat.action == csrc_pkg::ACT_PUT) begin
        empty_found = 1'b0;
        tgt = 0;
        for (int i = 0; i < n; i++) begin
          idx = (sweep_hand + i) % n;
          if (!empty_found && !shadow_valid[idx]) begin
            tgt = idx;
            empty_found = 1'b1;
          end
        end
        if (!empty_found) begin
          // Every frame is full: give referenced frames a second chance.
          while (shadow_ref[sweep_hand]) begin
            shadow_ref[sweep_hand] = 1'b0;
            sweep_hand = (sweep_hand + 1) % n;
          end
          tgt = sweep_hand;
          o.evicted = 1'b1;
          o.evicted_key = shadow_key[tgt];
        end else begin
          stored_count++;
        end
        shadow_key[tgt] = beat.key;
        shadow_valid[tgt] = 1'b1;
        shadow_ref[tgt] = 1'b1;
        sweep_hand = (tgt + 1) % n;
        o.slot = 4'(tgt);
      end
    end
    o.occupancy = 5'(stored_count);
    return o;
  endfunction

  function automatic plan_row_t item_row(logic [1:0] act, logic [31:0] k);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.cap = '0;
    row.beat.action = act;
    row.beat.key = k;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  // A request whose response, with no eviction, is written out by hand.
  function automatic plan_row_t checked_row(logic [1:0] act, logic [31:0] k, logic h,
                                            logic [31:0] v, logic [3:0] s, logic [4:0] occ);
    plan_row_t row;
    row = item_row(act, k);
    row.typed = 1'b1;
    row.want.hit = h;
    row.want.value = v;
    row.want.slot = s;
    row.want.occupancy = occ;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(logic [csrc_pkg::CAP_W-1:0] v);
    plan_row_t row;
    row = item_row(csrc_pkg::ACT_GET, '0);
    row.is_cfg = 1'b1;
    row.cap = v;
    return row;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string field, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
  endtask

  // Offers one request beat after a random gap and records its expected response.
  task automatic send_request(input csrc_pkg::req_t beat, input bit typed,
                              input csrc_pkg::rsp_t want);
    int             gap;
    csrc_pkg::rsp_t predicted;
    gap = 0;
    while (!quiet && $urandom_range(0, 99) < 35) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= beat;
    do @(posedge clk); while (req_stall !== 1'b0);
    predicted = second_chance_access(beat);
    pending_rsp.push_back(typed ? want : predicted);
    n_requests++;
    if (predicted.hit) n_hits++;
    if (predicted.evicted) n_evictions++;
    if (beat.action == csrc_pkg::ACT_SWEEP) n_sweeps++;
  endtask

  // Holds the request channel idle until every outstanding response has arrived.
  task automatic drain_responses();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // A capacity write also empties the store.
  task automatic write_capacity(input logic [csrc_pkg::CAP_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    capacity_reg = v;
    clear_shadow();
    n_settings++;
  endtask

  // The response side stalls at random, except during the quiet phase.
  always @(posedge clk) begin
    rsp_stall <= !quiet && ($urandom_range(0, 99) < 35);
  end

  // Each response beat is checked against the oldest expectation.
  always @(posedge clk) begin
    csrc_pkg::rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("response beat with nothing outstanding");
      end else begin
        want = pending_rsp.pop_front();
        check_field("hit", 32'(rsp.hit), 32'(want.hit));
        check_field("value", rsp.value, want.value);
        check_field("slot", 32'(rsp.slot), 32'(want.slot));
        check_field("evicted", 32'(rsp.evicted), 32'(want.evicted));
        check_field("evicted_key", rsp.evicted_key, want.evicted_key);
        check_field("occupancy", 32'(rsp.occupancy), 32'(want.occupancy));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    logic [31:0]    key_pool [$];
    csrc_pkg::req_t beat;
    int unsigned    n;
    int unsigned    pool_size;
    int unsigned    roll;

    clear_shadow();
    capacity_reg = csrc_pkg::ACTIVE_FRAMES_RESET;

    // Directed part: empty store, key extremes, repeated puts, every action,
    // eviction at a tiny capacity and both clamped capacities.
    directed_plan.push_back(checked_row(csrc_pkg::ACT_GET, 32'h0, 1'b0, 32'h0, 4'd0, 5'd0));
    directed_plan.push_back(checked_row(csrc_pkg::ACT_CONTAINS, 32'hFFFF_FFFF, 1'b0, 32'h0,
                                        4'd0, 5'd0));
    directed_plan.push_back(checked_row(csrc_pkg::ACT_SWEEP, 32'h0, 1'b0, 32'h0, 4'd0, 5'd0));
    directed_plan.push_back(checked_row(csrc_pkg::ACT_PUT, 32'h0, 1'b0, 32'h0, 4'd0, 5'd1));
    directed_plan.push_back(checked_row(csrc_pkg::ACT_PUT, 32'hFFFF_FFFF, 1'b0, 32'h0, 4'd1,
                                        5'd2));
    directed_plan.push_back(checked_row(csrc_pkg::ACT_GET, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
                                        4'd1, 5'd2));
    directed_plan.push_back(checked_row(csrc_pkg::ACT_CONTAINS, 32'h0, 1'b1, 32'h0, 4'd0,
                                        5'd2));
    directed_plan.push_back(checked_row(csrc_pkg::ACT_PUT, 32'h0, 1'b1, 32'h0, 4'd0, 5'd2));
    directed_plan.push_back(item_row(csrc_pkg::ACT_GET, 32'h1234_0000));
    directed_plan.push_back(cfg_row(5'd2));
    directed_plan.push_back(item_row(csrc_pkg::ACT_PUT, 32'hA5A5_A5A5));
    directed_plan.push_back(item_row(csrc_pkg::ACT_PUT, 32'h5A5A_5A5A));
    directed_plan.push_back(item_row(csrc_pkg::ACT_GET, 32'hA5A5_A5A5));
    directed_plan.push_back(item_row(csrc_pkg::ACT_PUT, 32'h1234_5678));
    directed_plan.push_back(item_row(csrc_pkg::ACT_SWEEP, 32'hFFFF_FFFF));
    directed_plan.push_back(item_row(csrc_pkg::ACT_PUT, 32'h8765_4321));
    directed_plan.push_back(item_row(csrc_pkg::ACT_CONTAINS, 32'h5A5A_5A5A));
    directed_plan.push_back(cfg_row(5'd0));
    directed_plan.push_back(checked_row(csrc_pkg::ACT_PUT, 32'h1, 1'b0, 32'h0, 4'd0, 5'd1));
    directed_plan.push_back(item_row(csrc_pkg::ACT_PUT, 32'h2));
    directed_plan.push_back(item_row(csrc_pkg::ACT_GET, 32'h2));
    directed_plan.push_back(cfg_row(5'd31));
    directed_plan.push_back(checked_row(csrc_pkg::ACT_PUT, 32'h3, 1'b0, 32'h0, 4'd0, 5'd1));
    directed_plan.push_back(item_row(csrc_pkg::ACT_GET, 32'h3));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) begin
        drain_responses();
        write_capacity(directed_plan[i].cap);
      end else begin
        send_request(directed_plan[i].beat, directed_plan[i].typed, directed_plan[i].want);
      end
    end

    // Random phases: each capacity setting draws keys mostly from a pool a little
    // larger than the capacity, so that hits and evictions are frequent.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_responses();
      write_capacity(phase_caps[ph]);
      quiet = (ph == QUIET_PHASE);
      n = effective_capacity(phase_caps[ph]);
      pool_size = n + $urandom_range(1, 4);
      key_pool.delete();
      for (int j = 0; j < pool_size; j++) key_pool.push_back($urandom);
      key_pool[0] = 32'h0;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int j = 0; j < PHASE_BEATS; j++) begin
        // Now and then the sender waits for the pipeline to empty completely.
        if (j == PHASE_BEATS / 2 && ph % 3 == 0) drain_responses();
        if ($urandom_range(0, 9) == 0) beat.key = $urandom;
        else beat.key = key_pool[$urandom_range(0, pool_size - 1)];
        roll = $urandom_range(0, 99);
        if (roll < 40) beat.action = csrc_pkg::ACT_PUT;
        else if (roll < 70) beat.action = csrc_pkg::ACT_GET;
        else if (roll < 88) beat.action = csrc_pkg::ACT_CONTAINS;
        else beat.action = csrc_pkg::ACT_SWEEP;
        send_request(beat, 1'b0, '0);
      end
    end
    quiet = 1'b0;

    drain_responses();
    repeat (40) @(posedge clk);

    $display("Run covered %0d requests over %0d capacity settings, extremes included.",
             n_requests, n_settings);
    $display("Predicted %0d hits, %0d evictions and %0d sweeps; %0d mismatches seen.",
             n_hits, n_evictions, n_sweeps, mismatches);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
